// ===== hw/rtl/pfla_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfla_pkg
// Shared widths, codes and controller/datapath interface types for the
// page free-list allocator.
// ----------------------------------------------------------------------------
package pfla_pkg;

  // Pool geometry
  localparam int unsigned MAX_PAGES  = 1024;
  localparam int unsigned PAGE_SHIFT = 12;
  localparam int unsigned IDX_W      = $clog2(MAX_PAGES);
  localparam int unsigned CNT_W      = 11;
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned PIDX_W     = ADDR_W - PAGE_SHIFT;
  localparam int unsigned STS_W      = 3;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned OUT_DATA_W = 48;

  localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(1024);
  localparam logic [CNT_W-1:0] MAX_CNT     = CNT_W'(MAX_PAGES);

  // Request kind
  typedef enum logic [0:0] {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  // Result status
  typedef enum logic [STS_W-1:0] {
    STS_OK          = 3'd0,
    STS_NO_PAGE     = 3'd1,
    STS_OUTSIDE     = 3'd2,
    STS_NOT_ALLOC   = 3'd3,
    STS_NULL_IGNORE = 3'd4
  } status_e;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE  = 1'b0,
    CFG_COUNT = 1'b1
  } cfg_idx_e;

  // Controller states
  typedef enum logic [0:0] {
    FSM_IDLE   = 1'b0,
    FSM_FINISH = 1'b1
  } fsm_state_e;

  // Controller to datapath
  typedef struct packed {
    logic capture;  // latch request, launch table reads
    logic commit;   // update state, load result beat
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free; // result register can take a beat this cycle
  } dp_status_t;

endpackage

// ===== hw/rtl/page_free_list_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_free_list_allocator
// Fixed pool of equal pages with a LIFO free list and a bump counter.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries requests: tuser is the command (0 allocate, 1 free),
//   tdata the byte address of the page to free. m_axis returns one beat per
//   request: tuser is the status, tdata the allocated page address and the
//   count of free pages left.
//   The cfg channel writes page_base_address (index 0) and page_count
//   (index 1); it is always ready. The user must write it only while no
//   request is in flight; the block itself does not enforce this.
//   A request is captured, then committed into the result register once that
//   register is free. A new request is accepted only after the previous one commits,
//   as the link and mark memory reads must complete before a pop or free can commit.
//   Reset clears the list head, bump counter and used count; the allocated
//   marks need no clearing pass since pages above the bump counter read as
//   unallocated. Config returns to base 0 and 1024 pages.
//   When m_axis stalls, one finished result waits in the output register
//   while the next request is accepted and decoded; its commit then waits
//   until the output register is free.
// ----------------------------------------------------------------------------
module page_free_list_allocator
  import pfla_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // config write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // request stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [ADDR_W-1:0]     s_axis_tdata,   // [31:0] address
  input  logic [0:0]            s_axis_tuser,   // [0] command
  // result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [31:0] page_address, [42:32] free_pages
  output logic [STS_W-1:0]      m_axis_tuser    // [2:0] status
);

  ctrl_cmd_t         cmd;
  dp_status_t        dp_status;
  logic [ADDR_W-1:0] res_addr;
  logic [CNT_W-1:0]  res_free;

  assign cfg_ready_o = 1'b1;

  // Sequencer
  pfla_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .status_i    (dp_status),
    .cmd_o       (cmd)
  );

  // Datapath
  pfla_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .req_cmd_i    (s_axis_tuser[0]),
    .req_addr_i   (s_axis_tdata),
    .cmd_i        (cmd),
    .status_o     (dp_status),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_status_o (m_axis_tuser),
    .res_addr_o   (res_addr),
    .res_free_o   (res_free)
  );

  // Pack result beat
  assign m_axis_tdata = {(OUT_DATA_W - ADDR_W - CNT_W)'(0), res_free, res_addr};

endmodule

// ===== hw/rtl/pfla_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfla_ctrl
// Two-state sequencer: takes a request, then commits it once the result
// register has room.
// ----------------------------------------------------------------------------
module pfla_ctrl
  import pfla_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       req_valid_i,
  output logic       req_ready_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  fsm_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      FSM_IDLE: begin
        if (req_valid_i) state_d = FSM_FINISH;
      end
      FSM_FINISH: begin
        if (status_i.out_free) state_d = FSM_IDLE;
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    req_ready_o   = 1'b0;
    cmd_o.capture = 1'b0;
    cmd_o.commit  = 1'b0;
    case (state_q)
      FSM_IDLE: begin
        req_ready_o   = 1'b1;
        cmd_o.capture = req_valid_i;
      end
      FSM_FINISH: begin
        cmd_o.commit = status_i.out_free;
      end
      default: ;
    endcase
  end

endmodule

// ===== hw/rtl/pfla_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfla_datapath
// Config registers, link and mark memories, list head and counters, request
// decode and the result register.
// ----------------------------------------------------------------------------
module pfla_datapath
  import pfla_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // config writes
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // request
  input  logic                  req_cmd_i,
  input  logic [ADDR_W-1:0]     req_addr_i,
  // control
  input  ctrl_cmd_t             cmd_i,
  output dp_status_t            status_o,
  // result
  output logic                  res_valid_o,
  input  logic                  res_ready_i,
  output logic [STS_W-1:0]      res_status_o,
  output logic [ADDR_W-1:0]     res_addr_o,
  output logic [CNT_W-1:0]      res_free_o
);

  // Config and allocator state
  logic [ADDR_W-1:0] base_q;
  logic [CNT_W-1:0]  count_q;
  logic [IDX_W-1:0]  head_q, head_d;
  logic [CNT_W-1:0]  fresh_q, fresh_d;
  logic [CNT_W-1:0]  used_q, used_d;
  logic [CNT_W-1:0]  pool;

  // Memories
  logic [IDX_W-1:0]  link_mem [MAX_PAGES];
  logic              mark_mem [MAX_PAGES];
  logic [IDX_W-1:0]  link_rd_q;
  logic              mark_rd_q;

  // Captured request
  logic              cmd_q;
  logic [IDX_W-1:0]  idx_q;
  logic              null_q, oob_q, mark_seen_q, pop_q, bump_q;

  // Capture-side decode
  logic [ADDR_W-1:0] diff;
  logic [PIDX_W-1:0] page_idx;
  logic [IDX_W-1:0]  free_idx;
  logic              below, oob, pop, bump;

  // Commit-side controls
  logic              mark_we, mark_wval, link_we;
  logic [STS_W-1:0]  sts_d;
  logic [ADDR_W-1:0] paddr_d;
  logic [CNT_W-1:0]  free_d;

  // Result register
  logic              res_valid_q;
  logic [STS_W-1:0]  res_status_q;
  logic [ADDR_W-1:0] res_addr_q;
  logic [CNT_W-1:0]  res_free_q;

  // Effective pool size
  assign pool = (count_q > MAX_CNT) ? MAX_CNT : count_q;

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= '0;
      count_q <= COUNT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_BASE:  base_q  <= cfg_data_i[ADDR_W-1:0];
        CFG_COUNT: count_q <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Request decode
  assign diff     = req_addr_i - base_q;
  assign below    = req_addr_i < base_q;
  assign page_idx = diff[ADDR_W-1:PAGE_SHIFT];
  assign free_idx = page_idx[IDX_W-1:0];
  assign oob      = below || (page_idx >= PIDX_W'(pool));
  assign pop      = fresh_q > used_q;
  assign bump     = fresh_q < pool;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q       <= req_cmd_i;
      null_q      <= (req_addr_i == '0);
      oob_q       <= oob;
      // pages at or above the bump counter were never issued: their mark is treated as clear
      mark_seen_q <= CNT_W'(free_idx) < fresh_q;
      pop_q       <= pop;
      bump_q      <= bump;
      if (req_cmd_i == CMD_FREE) begin
        idx_q <= free_idx;
      end else begin
        idx_q <= pop ? head_q : fresh_q[IDX_W-1:0];
      end
    end
  end

  // Link memory: read the head's link on capture, push on free commit
  always_ff @(posedge clk_i) begin
    if (link_we) link_mem[idx_q] <= head_q;
    if (cmd_i.capture) link_rd_q <= link_mem[head_q];
  end

  // Mark memory: read the freed page's mark on capture, update on commit
  always_ff @(posedge clk_i) begin
    if (mark_we) mark_mem[idx_q] <= mark_wval;
    if (cmd_i.capture) mark_rd_q <= mark_mem[free_idx];
  end

  // Commit decisions
  always_comb begin
    head_d    = head_q;
    fresh_d   = fresh_q;
    used_d    = used_q;
    mark_we   = 1'b0;
    mark_wval = 1'b0;
    link_we   = 1'b0;
    sts_d     = STS_OK;
    paddr_d   = '0;
    if (cmd_q == CMD_ALLOC) begin
      if (pop_q || bump_q) begin
        mark_we   = cmd_i.commit;
        mark_wval = 1'b1;
        used_d    = used_q + CNT_W'(1);
        paddr_d   = base_q + (ADDR_W'(idx_q) << PAGE_SHIFT);
        if (pop_q) begin
          head_d = link_rd_q;
        end else begin
          fresh_d = fresh_q + CNT_W'(1);
        end
      end else begin
        sts_d = STS_NO_PAGE;
      end
    end else begin
      if (null_q) begin
        sts_d = STS_NULL_IGNORE;
      end else if (oob_q) begin
        sts_d = STS_OUTSIDE;
      end else if (!(mark_seen_q && mark_rd_q)) begin
        sts_d = STS_NOT_ALLOC;
      end else begin
        mark_we   = cmd_i.commit;
        mark_wval = 1'b0;
        link_we   = cmd_i.commit;
        head_d    = idx_q;
        used_d    = used_q - CNT_W'(1);
      end
    end
    free_d = (pool > used_d) ? pool - used_d : '0;
  end

  // Allocator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      fresh_q <= '0;
      used_q  <= '0;
    end else if (cmd_i.commit) begin
      head_q  <= head_d;
      fresh_q <= fresh_d;
      used_q  <= used_d;
    end
  end

  // Result register
  assign status_o.out_free = !res_valid_q || res_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      res_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      res_status_q <= sts_d;
      res_addr_q   <= paddr_d;
      res_free_q   <= free_d;
    end
  end

  assign res_valid_o  = res_valid_q;
  assign res_status_o = res_status_q;
  assign res_addr_o   = res_addr_q;
  assign res_free_o   = res_free_q;

endmodule
